>>> design/ldad_pkg.sv
// Shared types, constants and helper functions for the line dipole anomaly block.
// Used by every module of the design; depends on nothing.

package ldad_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 48;
	localparam int NUM_VAL   = 6;
	localparam int ROOT_W    = 32;
	localparam int REM_W     = ROOT_W + 2;
	localparam int RAD_W     = 64;
	localparam int NORM_W    = 31;
	localparam int DIV_W     = 32;
	localparam int NUM_LANE  = 3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_POS_X  = 3'd0;
	localparam reg_idx_t REG_POS_Z  = 3'd1;
	localparam reg_idx_t REG_COEF_A = 3'd2;
	localparam reg_idx_t REG_COEF_B = 3'd3;
	localparam reg_idx_t REG_COEF_C = 3'd4;

	// The reciprocal lane divides 2^61; its upper 32 bits preload the remainder.
	localparam logic [DIV_W-1:0] IV_REM_INIT = 32'h2000_0000;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [63:0] LIM_POS = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;

	typedef struct packed {
		logic                    zero;
		logic                    sx;
		logic                    sz;
		logic signed [5:0]       e;
	} side_t;

	typedef struct packed {
		logic [ROOT_W-1:0]       root;
		logic [REM_W-1:0]        rem;
		logic [RAD_W-1:0]        rad;
		logic [NORM_W-1:0]       xm;
		logic [NORM_W-1:0]       zm;
	} sqrt_t;

	typedef struct packed {
		logic [DIV_W-1:0]        rem;
		logic [DIV_W-1:0]        low;
		logic [DIV_W-1:0]        quo;
	} div_lane_t;

	typedef struct packed {
		logic [DIV_W-1:0]        d;
		div_lane_t [NUM_LANE-1:0] lane;
	} div_t;

	typedef struct packed {
		logic                    zero;
		logic [NUM_VAL-1:0][OUT_W-1:0] val;
	} res_t;

	// Arithmetic right shift that rounds toward zero.
	function automatic logic signed [67:0] tzs(input logic signed [67:0] v, input logic [5:0] n);
		logic [67:0] mag;
		mag = v[67] ? 68'(-v) : 68'(v);
		mag = mag >> n;
		tzs = v[67] ? $signed(68'(-mag)) : $signed(mag);
	endfunction

	// Scales by 2^sh; right shifts round toward zero, the result saturates to 48 bits.
	function automatic logic [OUT_W-1:0] scale_sat(input logic signed [63:0] v,
			input logic signed [7:0] sh);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] r;
		logic [7:0]  n;
		logic        sat;
		neg = v[63];
		mag = neg ? 64'(-v) : 64'(v);
		r   = '0;
		sat = 1'b0;
		if (sh <= 8'sd0) begin
			n   = 8'(-sh);
			r   = (n >= 8'd64) ? '0 : mag >> n[5:0];
			sat = neg ? (r > LIM_NEG) : (r > LIM_POS);
		end else begin
			n = 8'(sh);
			if (mag != '0) begin
				sat = (n >= 8'd48) || ((mag >> (6'd47 - n[5:0])) != '0);
			end
			r = mag << n[5:0];
		end
		if (sat) begin
			scale_sat = neg ? OUT_MIN : OUT_MAX;
		end else begin
			scale_sat = neg ? OUT_W'(-r) : OUT_W'(r);
		end
	endfunction

endpackage

>>> design/line_dipole_anomaly_with_derivatives.sv
// Top level of the line dipole anomaly block: configuration registers, the
// front end, the square root and divider cell chains, the back end and the
// output register with its skid stage. Depends on ldad_pkg and all ldad_* modules.
//
//   channel   direction   contents (lowest bits first)
//   s_t*      in          tdata: obs_x, shift_x, shift_z (32 bits each)
//   m_t*      out         tdata: anomaly, lin_d_xz, lin_d_xx, lin_d_zz, pos_d_x,
//                                pos_d_z (48 bits each); tuser: zero_range
//   cfg_*     in          write: cfg_idx selects pos_x, pos_z, coef_a, coef_b, coef_c
//
// One word is accepted per cycle while the skid stage is empty. A result passes
// through the front end, the 32-stage square root chain, the 32-stage divider
// chain, the back end and the output register. Reset clears all valid bits and the
// configuration registers. When the output stalls, the word in flight lands in
// the skid stage and the pipeline then holds until the output drains.

module line_dipole_anomaly_with_derivatives
	import ldad_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [3*IN_W-1:0]        s_tdata,  // obs_x, shift_x, shift_z
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [NUM_VAL*OUT_W-1:0] m_tdata,  // anomaly, lin_d_xz, lin_d_xx, lin_d_zz, pos_d_x, pos_d_z
	output logic                     m_tuser,  // zero_range
	input  logic                     cfg_we,
	input  reg_idx_t                 cfg_idx,
	input  logic [IN_W-1:0]          cfg_data
);

	logic signed [IN_W-1:0] pos_x_q, pos_z_q, coef_a_q, coef_b_q, coef_c_q;

	logic en;
	logic out_vld_q, skid_vld_q;
	res_t out_q, skid_q;

	logic  sqv [0:ROOT_W];
	sqrt_t sqc [0:ROOT_W];
	side_t sqs [0:ROOT_W];

	logic  dvv [0:DIV_W];
	div_t  dvc [0:DIV_W];
	side_t dvs [0:DIV_W];

	logic back_vld;
	res_t back_res;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q  <= '0;
			pos_z_q  <= '0;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POS_X:  pos_x_q  <= cfg_data;
				REG_POS_Z:  pos_z_q  <= cfg_data;
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ldad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.obs_x    (s_tdata[IN_W-1:0]),
		.shift_x  (s_tdata[2*IN_W-1:IN_W]),
		.shift_z  (s_tdata[3*IN_W-1:2*IN_W]),
		.pos_x    (pos_x_q),
		.pos_z    (pos_z_q),
		.out_vld  (sqv[0]),
		.sq_out   (sqc[0]),
		.side_out (sqs[0])
	);

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		ldad_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (sqv[i]),
			.sq_in    (sqc[i]),
			.side_in  (sqs[i]),
			.vld_out  (sqv[i+1]),
			.sq_out   (sqc[i+1]),
			.side_out (sqs[i+1])
		);
	end

	// The dividends sit below 2^32 times the divisor, so their upper words preload
	// the remainders and 32 quotient bits remain.
	always_comb begin
		dvv[0]   = sqv[ROOT_W];
		dvs[0]   = sqs[ROOT_W];
		dvc[0].d = sqc[ROOT_W].root;
		dvc[0].lane[0].rem = DIV_W'(sqc[ROOT_W].xm >> 2);
		dvc[0].lane[0].low = {sqc[ROOT_W].xm[1:0], 30'd0};
		dvc[0].lane[0].quo = '0;
		dvc[0].lane[1].rem = DIV_W'(sqc[ROOT_W].zm >> 2);
		dvc[0].lane[1].low = {sqc[ROOT_W].zm[1:0], 30'd0};
		dvc[0].lane[1].quo = '0;
		dvc[0].lane[2].rem = IV_REM_INIT;
		dvc[0].lane[2].low = '0;
		dvc[0].lane[2].quo = '0;
	end

	for (genvar i = 0; i < DIV_W; i++) begin : g_div
		ldad_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (dvv[i]),
			.dv_in    (dvc[i]),
			.side_in  (dvs[i]),
			.vld_out  (dvv[i+1]),
			.dv_out   (dvc[i+1]),
			.side_out (dvs[i+1])
		);
	end

	ldad_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dvv[DIV_W]),
		.dv_in   (dvc[DIV_W]),
		.side_in (dvs[DIV_W]),
		.coef_a  (coef_a_q),
		.coef_b  (coef_b_q),
		.coef_c  (coef_c_q),
		.out_vld (back_vld),
		.res_out (back_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= back_vld;
			end
		end else if (back_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : back_res;
		end else if (en) begin
			skid_q <= back_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q.val;
	assign m_tuser  = out_q.zero;

endmodule

>>> design/ldad_front.sv
// Front end: offsets, magnitudes, normalizing exponent, normalized squares.
// Depends on ldad_pkg; feeds the square root cell chain.

module ldad_front
	import ldad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [IN_W-1:0] obs_x,
	input  logic signed [IN_W-1:0] shift_x,
	input  logic signed [IN_W-1:0] shift_z,
	input  logic signed [IN_W-1:0] pos_x,
	input  logic signed [IN_W-1:0] pos_z,
	output logic                   out_vld,
	output sqrt_t                  sq_out,
	output side_t                  side_out
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [33:0] x_s1;
	logic signed [32:0] z_s1;

	logic [32:0] ax_s2, az_s2, m_s2;
	logic        sx_s2, sz_s2;

	logic [4:0]  phi_s3;
	logic [3:0]  plo_s3;
	logic        hi_s3, lo_s3;
	logic [32:0] ax_s3, az_s3;
	logic        sx_s3, sz_s3;

	logic [32:0] ax_s4, az_s4;
	side_t       side_s4;

	logic [NORM_W-1:0] xm_s5, zm_s5;
	side_t             side_s5;

	logic [2*NORM_W-1:0] xx_s6, zz_s6;
	logic [NORM_W-1:0]   xm_s6, zm_s6;
	side_t               side_s6;

	logic [2*NORM_W:0]   sn_s7;
	logic [NORM_W-1:0]   xm_s7, zm_s7;
	side_t               side_s7;

	logic [32:0] ax_n, az_n;
	logic [4:0]  phi_n;
	logic [3:0]  plo_n;
	logic signed [5:0] e_n;

	always_comb begin
		ax_n = x_s1[33] ? 33'(-x_s1) : 33'(x_s1);
		az_n = z_s1[32] ? 33'(-z_s1) : 33'(z_s1);
	end

	// Leading one of the larger magnitude, found in two halves.
	always_comb begin
		phi_n = '0;
		plo_n = '0;
		for (int i = 0; i < 17; i++) begin
			if (m_s2[16+i]) phi_n = 5'(i);
		end
		for (int i = 0; i < 16; i++) begin
			if (m_s2[i]) plo_n = 4'(i);
		end
	end

	always_comb begin
		if (hi_s3) begin
			e_n = 6'(int'(phi_s3) + 17 - 31);
		end else if (lo_s3) begin
			e_n = 6'(int'(plo_s3) + 1 - 31);
		end else begin
			e_n = 6'(-31);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= 34'(obs_x) + 34'(shift_x) - 34'(pos_x);
			z_s1 <= 33'(pos_z) - 33'(shift_z);

			ax_s2 <= ax_n;
			az_s2 <= az_n;
			m_s2  <= (ax_n > az_n) ? ax_n : az_n;
			sx_s2 <= x_s1[33];
			sz_s2 <= z_s1[32];

			phi_s3 <= phi_n;
			plo_s3 <= plo_n;
			hi_s3  <= |m_s2[32:16];
			lo_s3  <= |m_s2[15:0];
			ax_s3  <= ax_s2;
			az_s3  <= az_s2;
			sx_s3  <= sx_s2;
			sz_s3  <= sz_s2;

			ax_s4        <= ax_s3;
			az_s4        <= az_s3;
			side_s4.zero <= !(hi_s3 || lo_s3);
			side_s4.sx   <= sx_s3;
			side_s4.sz   <= sz_s3;
			side_s4.e    <= e_n;

			// Exact left shift for small offsets, truncating right shift for large ones.
			if (side_s4.e > 6'sd0) begin
				xm_s5 <= NORM_W'(ax_s4 >> $unsigned(side_s4.e));
				zm_s5 <= NORM_W'(az_s4 >> $unsigned(side_s4.e));
			end else begin
				xm_s5 <= NORM_W'(ax_s4 << $unsigned(6'(-side_s4.e)));
				zm_s5 <= NORM_W'(az_s4 << $unsigned(6'(-side_s4.e)));
			end
			side_s5 <= side_s4;

			xx_s6   <= xm_s5 * xm_s5;
			zz_s6   <= zm_s5 * zm_s5;
			xm_s6   <= xm_s5;
			zm_s6   <= zm_s5;
			side_s6 <= side_s5;

			sn_s7   <= (2*NORM_W+1)'(xx_s6) + (2*NORM_W+1)'(zz_s6);
			xm_s7   <= xm_s6;
			zm_s7   <= zm_s6;
			side_s7 <= side_s6;
		end
	end

	always_comb begin
		out_vld     = vld_s7;
		side_out    = side_s7;
		sq_out.root = '0;
		sq_out.rem  = '0;
		sq_out.rad  = RAD_W'(sn_s7);
		sq_out.xm   = xm_s7;
		sq_out.zm   = zm_s7;
	end

endmodule

>>> design/ldad_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
// Depends on ldad_pkg.

module ldad_sqrt_cell
	import ldad_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  sqrt_t sq_in,
	input  side_t side_in,
	output logic  vld_out,
	output sqrt_t sq_out,
	output side_t side_out
);

	logic [REM_W:0] cand;
	logic [REM_W:0] trial;
	sqrt_t          nxt;

	always_comb begin
		cand  = {sq_in.rem[REM_W-2:0], sq_in.rad[RAD_W-1 -: 2]};
		trial = {1'b0, sq_in.root, 2'b01};
		nxt   = sq_in;
		nxt.rad = {sq_in.rad[RAD_W-3:0], 2'b00};
		if (cand >= trial) begin
			nxt.rem  = REM_W'(cand - trial);
			nxt.root = {sq_in.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cand[REM_W-1:0];
			nxt.root = {sq_in.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_out   <= nxt;
			side_out <= side_in;
		end
	end

endmodule

>>> design/ldad_div_cell.sv
// One cell of the divider chain: one quotient bit for the two direction
// cosines and the reciprocal range. Depends on ldad_pkg.

module ldad_div_cell
	import ldad_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  div_t  dv_in,
	input  side_t side_in,
	output logic  vld_out,
	output div_t  dv_out,
	output side_t side_out
);

	logic [DIV_W:0] r2;
	logic           ge;
	div_t           nxt;

	always_comb begin
		nxt = dv_in;
		r2  = '0;
		ge  = 1'b0;
		for (int i = 0; i < NUM_LANE; i++) begin
			r2 = {dv_in.lane[i].rem, dv_in.lane[i].low[DIV_W-1]};
			ge = (r2 >= {1'b0, dv_in.d});
			nxt.lane[i].rem = ge ? DIV_W'(r2 - {1'b0, dv_in.d}) : r2[DIV_W-1:0];
			nxt.lane[i].low = {dv_in.lane[i].low[DIV_W-2:0], 1'b0};
			nxt.lane[i].quo = {dv_in.lane[i].quo[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_out   <= nxt;
			side_out <= side_in;
		end
	end

endmodule

>>> design/ldad_back.sv
// Back end: products, anomaly and derivative terms, scaling and saturation.
// Depends on ldad_pkg; takes the quotients from the divider chain.

module ldad_back
	import ldad_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  div_t                   dv_in,
	input  side_t                  side_in,
	input  logic signed [IN_W-1:0] coef_a,
	input  logic signed [IN_W-1:0] coef_b,
	input  logic signed [IN_W-1:0] coef_c,
	output logic                   out_vld,
	output res_t                   res_out
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;
	side_t side_s10;

	logic signed [31:0] u_s1, w_s1, u_s2, w_s2, u_s3, w_s3, u_s4, w_s4, u_s5, w_s5, u_s6, w_s6;
	logic [31:0] iv_s1, iv_s2, iv_s3, iv_s4, iv_s5, iv_s6;

	logic signed [63:0] uw_s2, uu_s2, ww_s2;
	logic [63:0] ivsq_s2;

	logic signed [31:0] pxz_s3, pxx_s3, pzz_s3, pxz_s4, pxx_s4, pzz_s4;
	logic signed [31:0] pxz_s5, pxx_s5, pzz_s5, pxz_s6, pxx_s6, pzz_s6;
	logic [31:0] iv2_s3;

	logic signed [63:0] ap_s4, bp_s4, cp_s4, ub_s4, wa_s4, wc_s4, ua_s4;
	logic [63:0] iv3p_s4;

	logic signed [65:0] q_s5;
	logic [31:0] iv3_s5, iv3_s6;
	logic signed [63:0] ub1_s5, wa2_s5, wc1_s5, ua2_s5, ub1_s6, wa2_s6, wc1_s6, ua2_s6;
	logic signed [63:0] ub1_s7, wa2_s7, wc1_s7, ua2_s7;

	logic signed [31:0] qr_s6;

	logic signed [63:0] qu_s7, qw_s7;
	logic signed [63:0] anp_s7, lxz_s7, lxx_s7, lzz_s7;
	logic signed [63:0] anp_s8, lxz_s8, lxx_s8, lzz_s8;
	logic signed [63:0] anp_s9, lxz_s9, lxx_s9, lzz_s9;
	logic signed [63:0] anp_s10, lxz_s10, lxx_s10, lzz_s10;
	logic [63:0] iv4p_s7;

	logic signed [67:0] px_s8, pz_s8;
	logic [31:0] iv4_s8, iv4_s9;

	logic signed [31:0] px32_s9, pz32_s9;
	logic signed [63:0] ppx_s10, ppz_s10;
	logic signed [7:0]  sh_an_s10, sh_lin_s10, sh_pos_s10;

	res_t res_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Direction cosines get the sign of their offsets back.
			u_s1    <= side_in.sx ? -$signed(dv_in.lane[0].quo) : $signed(dv_in.lane[0].quo);
			w_s1    <= side_in.sz ? -$signed(dv_in.lane[1].quo) : $signed(dv_in.lane[1].quo);
			iv_s1   <= dv_in.lane[2].quo;
			side_s1 <= side_in;

			uw_s2   <= u_s1 * w_s1;
			uu_s2   <= u_s1 * u_s1;
			ww_s2   <= w_s1 * w_s1;
			ivsq_s2 <= iv_s1 * iv_s1;
			u_s2    <= u_s1;
			w_s2    <= w_s1;
			iv_s2   <= iv_s1;
			side_s2 <= side_s1;

			pxz_s3  <= 32'(tzs(68'(uw_s2), 6'd30));
			pxx_s3  <= 32'(tzs(68'(uu_s2), 6'd30));
			pzz_s3  <= 32'(tzs(68'(ww_s2), 6'd30));
			iv2_s3  <= 32'(ivsq_s2 >> 31);
			u_s3    <= u_s2;
			w_s3    <= w_s2;
			iv_s3   <= iv_s2;
			side_s3 <= side_s2;

			ap_s4   <= coef_a * pxz_s3;
			bp_s4   <= coef_b * pxx_s3;
			cp_s4   <= coef_c * pzz_s3;
			iv3p_s4 <= iv2_s3 * iv_s3;
			ub_s4   <= u_s3 * coef_b;
			wa_s4   <= w_s3 * coef_a;
			wc_s4   <= w_s3 * coef_c;
			ua_s4   <= u_s3 * coef_a;
			u_s4    <= u_s3;
			w_s4    <= w_s3;
			pxz_s4  <= pxz_s3;
			pxx_s4  <= pxx_s3;
			pzz_s4  <= pzz_s3;
			iv_s4   <= iv_s3;
			side_s4 <= side_s3;

			q_s5    <= 66'(ap_s4) + 66'(bp_s4) + 66'(cp_s4);
			iv3_s5  <= 32'(iv3p_s4 >> 31);
			ub1_s5  <= 64'(tzs(68'(ub_s4), 6'd1));
			wa2_s5  <= 64'(tzs(68'(wa_s4), 6'd2));
			wc1_s5  <= 64'(tzs(68'(wc_s4), 6'd1));
			ua2_s5  <= 64'(tzs(68'(ua_s4), 6'd2));
			u_s5    <= u_s4;
			w_s5    <= w_s4;
			pxz_s5  <= pxz_s4;
			pxx_s5  <= pxx_s4;
			pzz_s5  <= pzz_s4;
			iv_s5   <= iv_s4;
			side_s5 <= side_s4;

			qr_s6   <= 32'(tzs(68'(q_s5), 6'd32));
			iv3_s6  <= iv3_s5;
			ub1_s6  <= ub1_s5;
			wa2_s6  <= wa2_s5;
			wc1_s6  <= wc1_s5;
			ua2_s6  <= ua2_s5;
			u_s6    <= u_s5;
			w_s6    <= w_s5;
			pxz_s6  <= pxz_s5;
			pxx_s6  <= pxx_s5;
			pzz_s6  <= pzz_s5;
			iv_s6   <= iv_s5;
			side_s6 <= side_s5;

			qu_s7   <= qr_s6 * u_s6;
			qw_s7   <= qr_s6 * w_s6;
			anp_s7  <= qr_s6 * $signed({1'b0, iv3_s6});
			lxz_s7  <= pxz_s6 * $signed({1'b0, iv3_s6});
			lxx_s7  <= pxx_s6 * $signed({1'b0, iv3_s6});
			lzz_s7  <= pzz_s6 * $signed({1'b0, iv3_s6});
			iv4p_s7 <= iv3_s6 * iv_s6;
			ub1_s7  <= ub1_s6;
			wa2_s7  <= wa2_s6;
			wc1_s7  <= wc1_s6;
			ua2_s7  <= ua2_s6;
			side_s7 <= side_s6;

			px_s8   <= (68'(qu_s7) <<< 2) + 68'(qu_s7) - 68'(ub1_s7) - 68'(wa2_s7);
			pz_s8   <= 68'(wc1_s7) + 68'(ua2_s7) - (68'(qw_s7) <<< 2) - 68'(qw_s7);
			iv4_s8  <= 32'(iv4p_s7 >> 31);
			anp_s8  <= anp_s7;
			lxz_s8  <= lxz_s7;
			lxx_s8  <= lxx_s7;
			lzz_s8  <= lzz_s7;
			side_s8 <= side_s7;

			px32_s9 <= 32'(tzs(px_s8, 6'd32));
			pz32_s9 <= 32'(tzs(pz_s8, 6'd32));
			iv4_s9  <= iv4_s8;
			anp_s9  <= anp_s8;
			lxz_s9  <= lxz_s8;
			lxx_s9  <= lxx_s8;
			lzz_s9  <= lzz_s8;
			side_s9 <= side_s8;

			ppx_s10    <= px32_s9 * $signed({1'b0, iv4_s9});
			ppz_s10    <= pz32_s9 * $signed({1'b0, iv4_s9});
			sh_an_s10  <= 8'(2*FRAC_BITS - 3*int'(side_s9.e) - 87);
			sh_lin_s10 <= 8'(3*FRAC_BITS - 3*int'(side_s9.e) - 119);
			sh_pos_s10 <= 8'(3*FRAC_BITS - 4*int'(side_s9.e) - 115);
			anp_s10    <= anp_s9;
			lxz_s10    <= lxz_s9;
			lxx_s10    <= lxx_s9;
			lzz_s10    <= lzz_s9;
			side_s10   <= side_s9;

			// A zero range forces every value to zero and raises the flag.
			res_s11.zero <= side_s10.zero;
			if (side_s10.zero) begin
				res_s11.val <= '0;
			end else begin
				res_s11.val[0] <= scale_sat(anp_s10, sh_an_s10);
				res_s11.val[1] <= scale_sat(lxz_s10, sh_lin_s10);
				res_s11.val[2] <= scale_sat(lxx_s10, sh_lin_s10);
				res_s11.val[3] <= scale_sat(lzz_s10, sh_lin_s10);
				res_s11.val[4] <= scale_sat(ppx_s10, sh_pos_s10);
				res_s11.val[5] <= scale_sat(ppz_s10, sh_pos_s10);
			end
		end
	end

	assign out_vld = vld_s11;
	assign res_out = res_s11;

endmodule
